// ===== rtl/riscv_relocation_patcher_top_macros.svh =====
// Assertion macros used by the checker file.
`ifndef RISCV_RELOCATION_PATCHER_TOP_MACROS_SVH
`define RISCV_RELOCATION_PATCHER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define RRP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("rrp assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define RRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("rrp assertion failed");

`endif

// ===== rtl/rrp_pkg.sv =====
package rrp_pkg;

	localparam logic [7:0] MODE_ABS64      = 8'd2;
	localparam logic [7:0] MODE_BRANCH     = 8'd16;
	localparam logic [7:0] MODE_JAL        = 8'd17;
	localparam logic [7:0] MODE_CALL       = 8'd18;
	localparam logic [7:0] MODE_CALL_PLT   = 8'd19;
	localparam logic [7:0] MODE_HI20       = 8'd23;
	localparam logic [7:0] MODE_LO12_I     = 8'd24;
	localparam logic [7:0] MODE_LO12_S     = 8'd25;
	localparam logic [7:0] MODE_ADD32      = 8'd35;
	localparam logic [7:0] MODE_SUB32      = 8'd39;
	localparam logic [7:0] MODE_RVC_BRANCH = 8'd44;
	localparam logic [7:0] MODE_RVC_JUMP   = 8'd45;
	localparam logic [7:0] MODE_RELAX      = 8'd51;

	localparam logic [1:0] ST_PATCHED = 2'd0;
	localparam logic [1:0] ST_RELAX   = 2'd1;
	localparam logic [1:0] ST_UNKNOWN = 2'd2;
	localparam logic [1:0] ST_NO_PAIR = 2'd3;

	localparam logic [31:0] HI_ROUND = 32'h0000_0800;
	localparam logic [31:0] HI_MASK  = 32'hffff_f000;

	typedef enum logic [3:0] {
		OP_ABS64,
		OP_HI20,
		OP_JAL,
		OP_CALL,
		OP_BRANCH,
		OP_RVC_JUMP,
		OP_RVC_BRANCH,
		OP_RELAX,
		OP_ADD32,
		OP_SUB32,
		OP_LO12_I,
		OP_LO12_S,
		OP_UNKNOWN
	} op_t;

	// Stage 1 beat: target formed, operands carried.
	typedef struct packed {
		logic [7:0]  mode;
		logic [63:0] tgt;
		logic [31:0] loc_lo;
		logic [31:0] w0;
		logic [31:0] w1;
		logic [11:0] pair_lo;
		logic        found;
	} s1_t;

	// Stage 2 beat: decoded op and PC-relative offset.
	typedef struct packed {
		op_t         op;
		logic [63:0] tgt;
		logic [31:0] off;
		logic [31:0] w0;
		logic [31:0] w1;
		logic [11:0] pair_lo;
		logic        found;
	} s2_t;

	// Result beat.
	typedef struct packed {
		logic [31:0] new_low;
		logic [31:0] new_high;
		logic        write_high;
		logic        half_only;
		logic [1:0]  status;
	} res_t;

	function automatic op_t decode(input logic [7:0] mode);
		op_t op;
		case (mode)
			MODE_ABS64:                op = OP_ABS64;
			MODE_HI20:                 op = OP_HI20;
			MODE_JAL:                  op = OP_JAL;
			MODE_CALL, MODE_CALL_PLT:  op = OP_CALL;
			MODE_BRANCH:               op = OP_BRANCH;
			MODE_RVC_JUMP:             op = OP_RVC_JUMP;
			MODE_RVC_BRANCH:           op = OP_RVC_BRANCH;
			MODE_RELAX:                op = OP_RELAX;
			MODE_ADD32:                op = OP_ADD32;
			MODE_SUB32:                op = OP_SUB32;
			MODE_LO12_I:               op = OP_LO12_I;
			MODE_LO12_S:               op = OP_LO12_S;
			default:                   op = OP_UNKNOWN;
		endcase
		return op;
	endfunction

endpackage

// ===== rtl/rrp_sum.sv =====
module rrp_sum (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_v,
	input  logic [7:0]          mode,
	input  logic [63:0]         location,
	input  logic [63:0]         symbol_value,
	input  logic signed [63:0]  addend,
	input  logic [31:0]         word_low,
	input  logic [31:0]         word_high,
	input  logic signed [31:0]  pair_offset,
	input  logic                pair_found,
	output logic                v_s1,
	output rrp_pkg::s1_t        d_s1
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
		end
	end

	// Form the 64-bit target; only the low word of the address is needed later.
	always_ff @(posedge clk) begin
		if (en) begin
			d_s1.mode    <= mode;
			d_s1.tgt     <= symbol_value + $unsigned(addend);
			d_s1.loc_lo  <= location[31:0];
			d_s1.w0      <= word_low;
			d_s1.w1      <= word_high;
			d_s1.pair_lo <= pair_offset[11:0];
			d_s1.found   <= pair_found;
		end
	end

endmodule

// ===== rtl/rrp_offset.sv =====
module rrp_offset (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         v_s1,
	input  rrp_pkg::s1_t d_s1,
	output logic         v_s2,
	output rrp_pkg::s2_t d_s2
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	// Offset is taken mod 2^32, so the low words suffice.
	always_ff @(posedge clk) begin
		if (en) begin
			d_s2.op      <= rrp_pkg::decode(d_s1.mode);
			d_s2.tgt     <= d_s1.tgt;
			d_s2.off     <= d_s1.tgt[31:0] - d_s1.loc_lo;
			d_s2.w0      <= d_s1.w0;
			d_s2.w1      <= d_s1.w1;
			d_s2.pair_lo <= d_s1.pair_lo;
			d_s2.found   <= d_s1.found;
		end
	end

endmodule

// ===== rtl/rrp_patch.sv =====
module rrp_patch (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_s2,
	input  rrp_pkg::s2_t  d_s2,
	output logic          v_s3,
	output rrp_pkg::res_t r_s3
);

	logic [31:0]   hi;
	logic [31:0]   off;
	logic [31:0]   w0;
	logic [31:0]   w1;
	logic [11:0]   pl;
	rrp_pkg::res_t r;

	assign off = d_s2.off;
	assign w0  = d_s2.w0;
	assign w1  = d_s2.w1;
	assign pl  = d_s2.pair_lo;
	assign hi  = (off + rrp_pkg::HI_ROUND) & rrp_pkg::HI_MASK;

	// Low 12 bits of (x - hi_part(x)) are just the low 12 bits of x.
	always_comb begin
		r.new_low    = w0;
		r.new_high   = w1;
		r.write_high = 1'b0;
		r.half_only  = 1'b0;
		r.status     = rrp_pkg::ST_PATCHED;
		case (d_s2.op)
			rrp_pkg::OP_ABS64: begin
				r.new_low    = d_s2.tgt[31:0];
				r.new_high   = d_s2.tgt[63:32];
				r.write_high = 1'b1;
			end
			rrp_pkg::OP_HI20: begin
				r.new_low = {hi[31:12], w0[11:0]};
			end
			rrp_pkg::OP_JAL: begin
				r.new_low = {off[20], off[10:1], off[11], off[19:12], w0[11:0]};
			end
			rrp_pkg::OP_CALL: begin
				r.new_low    = {hi[31:12], w0[11:0]};
				r.new_high   = {off[11:0], w1[19:0]};
				r.write_high = 1'b1;
			end
			rrp_pkg::OP_BRANCH: begin
				r.new_low = {off[12], off[10:5], w0[24:12], off[4:1], off[11], w0[6:0]};
			end
			rrp_pkg::OP_RVC_JUMP: begin
				r.new_low   = {w0[31:13], off[11], off[4], off[9:8], off[10], off[6],
					off[7], off[3:1], off[5], w0[1:0]};
				r.half_only = 1'b1;
			end
			rrp_pkg::OP_RVC_BRANCH: begin
				r.new_low   = {w0[31:13], off[8], off[4:3], w0[9:7], off[7:6], off[2:1],
					off[5], w0[1:0]};
				r.half_only = 1'b1;
			end
			rrp_pkg::OP_RELAX: begin
				r.status = rrp_pkg::ST_RELAX;
			end
			rrp_pkg::OP_ADD32: begin
				r.new_low = w0 + d_s2.tgt[31:0];
			end
			rrp_pkg::OP_SUB32: begin
				r.new_low = w0 - d_s2.tgt[31:0];
			end
			rrp_pkg::OP_LO12_I: begin
				if (d_s2.found) begin
					r.new_low = {pl, w0[19:0]};
				end else begin
					r.status = rrp_pkg::ST_NO_PAIR;
				end
			end
			rrp_pkg::OP_LO12_S: begin
				if (d_s2.found) begin
					r.new_low = {pl[11:5], w0[24:12], pl[4:0], w0[6:0]};
				end else begin
					r.status = rrp_pkg::ST_NO_PAIR;
				end
			end
			default: begin
				r.status = rrp_pkg::ST_UNKNOWN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s3 <= r;
		end
	end

endmodule

// ===== rtl/riscv_relocation_patcher_top.sv =====
// Each input beat passes the stage 1, stage 2 and result registers before it leaves as a result beat.
// Throughput: one relocation per cycle while out_ready is high; every stage holds one beat.
// Stages: target add, offset subtract and type decode, immediate scatter and word select.
// Reset (arst_n low, asynchronous) clears all stage valid bits; payload is not reset.
module riscv_relocation_patcher_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         mode,
	input  logic [63:0]        location,
	input  logic [63:0]        symbol_value,
	input  logic signed [63:0] addend,
	input  logic [31:0]        word_low,
	input  logic [31:0]        word_high,
	input  logic signed [31:0] pair_offset,
	input  logic               pair_found,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        new_low,
	output logic [31:0]        new_high,
	output logic               write_high,
	output logic               half_only,
	output logic [1:0]         status
);

	logic          v_s1;
	logic          v_s2;
	logic          v_s3;
	logic          en1;
	logic          en2;
	logic          en3;
	rrp_pkg::s1_t  d_s1;
	rrp_pkg::s2_t  d_s2;
	rrp_pkg::res_t r_s3;

	// A stage loads when it is empty or its beat moves on in the same cycle.
	// Bubbles collapse, so a stalled output still lets upstream stages fill.
	assign en3      = !v_s3 || out_ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	// Stage 1: 64-bit target = symbol value + addend.
	rrp_sum u_sum (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en1),
		.in_v         (in_valid),
		.mode         (mode),
		.location     (location),
		.symbol_value (symbol_value),
		.addend       (addend),
		.word_low     (word_low),
		.word_high    (word_high),
		.pair_offset  (pair_offset),
		.pair_found   (pair_found),
		.v_s1         (v_s1),
		.d_s1         (d_s1)
	);

	// Stage 2: 32-bit PC-relative offset and type decode.
	rrp_offset u_offset (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en2),
		.v_s1   (v_s1),
		.d_s1   (d_s1),
		.v_s2   (v_s2),
		.d_s2   (d_s2)
	);

	// Stage 3: HI20 rounding, immediate scatter, result register.
	rrp_patch u_patch (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en3),
		.v_s2   (v_s2),
		.d_s2   (d_s2),
		.v_s3   (v_s3),
		.r_s3   (r_s3)
	);

	// Drive the result beat straight from the last stage register.
	assign out_valid  = v_s3;
	assign new_low    = r_s3.new_low;
	assign new_high   = r_s3.new_high;
	assign write_high = r_s3.write_high;
	assign half_only  = r_s3.half_only;
	assign status     = r_s3.status;

endmodule

// ===== rtl/rrp_checker.sv =====
`include "riscv_relocation_patcher_top_macros.svh"

module rrp_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [31:0]        new_low,
	input  logic [31:0]        new_high,
	input  logic               write_high,
	input  logic               half_only,
	input  logic [1:0]         status
);

	logic stalled;

	assign stalled = out_valid && !out_ready;

	// Hold a stalled result beat.
	`RRP_ASSERT_NEXT(a_out_hold, clk, arst_n, stalled, out_valid)
	`RRP_ASSERT_NEXT(a_out_stable, clk, arst_n, stalled,
		$stable(new_low) && $stable(new_high) && $stable(status))
	// A compressed patch never writes the second word.
	`RRP_ASSERT_IMPLY(a_half_excl, clk, arst_n, out_valid && half_only, !write_high)
	// Non-patched status writes nothing beyond the unchanged low word.
	`RRP_ASSERT_IMPLY(a_status_nowrite, clk, arst_n,
		out_valid && (status != rrp_pkg::ST_PATCHED),
		!write_high && !half_only)

endmodule

bind riscv_relocation_patcher_top rrp_checker u_rrp_checker (.*);

// ===== verif/tb_riscv_relocation_patcher_top.sv =====
`timescale 1ns / 1ps

module tb_riscv_relocation_patcher_top;
	import rrp_pkg::*;

	// One relocation entry as the sender presents it.
	typedef struct packed {
		logic [7:0]         mode;
		logic [63:0]        location;
		logic [63:0]        symbol_value;
		logic signed [63:0] addend;
		logic [31:0]        word_low;
		logic [31:0]        word_high;
		logic signed [31:0] pair_offset;
		logic               pair_found;
	} reloc_t;

	localparam int HOLD_CYCLES = 300;
	localparam logic [63:0] BASE = 64'h0000_0000_8000_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Sender side: payload lives in cur_beat, every field is its own port.
	logic   in_valid = 1'b0;
	logic   in_ready;
	reloc_t cur_beat = '0;

	// Receiver side.
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] new_low;
	logic [31:0] new_high;
	logic        write_high;
	logic        half_only;
	logic [1:0]  status;

	// Relocations waiting to be offered, and patched words still owed by the block.
	reloc_t reloc_q[$];
	res_t   patched_words_q[$];

	int send_idle_pct = 31;
	int recv_idle_pct = 58;
	int mismatch_count = 0;

	// Long receiver hold-off; armed by the stimulus, counted by the receiver itself.
	logic hold_armed = 1'b0;
	logic hold_done = 1'b0;
	int   hold_count = 0;

	riscv_relocation_patcher_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (cur_beat.mode),
		.location     (cur_beat.location),
		.symbol_value (cur_beat.symbol_value),
		.addend       (cur_beat.addend),
		.word_low     (cur_beat.word_low),
		.word_high    (cur_beat.word_high),
		.pair_offset  (cur_beat.pair_offset),
		.pair_found   (cur_beat.pair_found),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.new_low      (new_low),
		.new_high     (new_high),
		.write_high   (write_high),
		.half_only    (half_only),
		.status       (status)
	);

	always #2 clk = ~clk;

	// Upper 20 bits of an offset, rounded so that the signed low 12 bits make up the rest.
	function automatic logic [31:0] rounded_upper(input logic [31:0] off);
		return (off + HI_ROUND) & HI_MASK;
	endfunction

	// Work out the patched words, write flags and status for one relocation.
	function automatic res_t patch_words(input reloc_t r);
		logic [63:0] tgt;
		logic [31:0] off;
		logic [31:0] hi;
		logic [31:0] lo;
		logic [31:0] w0;
		res_t e;
		tgt = r.symbol_value + r.addend;
		off = tgt[31:0] - r.location[31:0];
		w0 = r.word_low;
		e.new_low = r.word_low;
		e.new_high = r.word_high;
		e.write_high = 1'b0;
		e.half_only = 1'b0;
		e.status = ST_PATCHED;
		case (r.mode)
			MODE_ABS64: begin
				e.new_low = tgt[31:0];
				e.new_high = tgt[63:32];
				e.write_high = 1'b1;
			end
			MODE_HI20: begin
				hi = rounded_upper(off);
				e.new_low = {hi[31:12], w0[11:0]};
			end
			MODE_JAL: e.new_low = {off[20], off[10:1], off[11], off[19:12], w0[11:0]};
			MODE_CALL, MODE_CALL_PLT: begin
				hi = rounded_upper(off);
				lo = off - hi;
				e.new_low = {hi[31:12], w0[11:0]};
				e.new_high = {lo[11:0], r.word_high[19:0]};
				e.write_high = 1'b1;
			end
			MODE_BRANCH:
				e.new_low = {off[12], off[10:5], w0[24:12], off[4:1], off[11], w0[6:0]};
			MODE_RVC_JUMP: begin
				e.new_low = {w0[31:13], off[11], off[4], off[9:8], off[10], off[6], off[7],
					off[3:1], off[5], w0[1:0]};
				e.half_only = 1'b1;
			end
			MODE_RVC_BRANCH: begin
				e.new_low = {w0[31:13], off[8], off[4:3], w0[9:7], off[7:6], off[2:1],
					off[5], w0[1:0]};
				e.half_only = 1'b1;
			end
			MODE_RELAX: e.status = ST_RELAX;
			MODE_ADD32: e.new_low = w0 + tgt[31:0];
			MODE_SUB32: e.new_low = w0 - tgt[31:0];
			MODE_LO12_I, MODE_LO12_S: begin
				if (!r.pair_found) begin
					e.status = ST_NO_PAIR;
				end else begin
					lo = r.pair_offset - rounded_upper(r.pair_offset);
					if (r.mode == MODE_LO12_I)
						e.new_low = {lo[11:0], w0[19:0]};
					else
						e.new_low = {lo[11:5], w0[24:12], lo[4:0], w0[6:0]};
				end
			end
			default: e.status = ST_UNKNOWN;
		endcase
		return e;
	endfunction

	function automatic logic [7:0] known_mode(input int idx);
		case (idx)
			0:       return MODE_ABS64;
			1:       return MODE_BRANCH;
			2:       return MODE_JAL;
			3:       return MODE_CALL;
			4:       return MODE_CALL_PLT;
			5:       return MODE_HI20;
			6:       return MODE_LO12_I;
			7:       return MODE_LO12_S;
			8:       return MODE_ADD32;
			9:       return MODE_SUB32;
			10:      return MODE_RVC_BRANCH;
			11:      return MODE_RVC_JUMP;
			default: return MODE_RELAX;
		endcase
	endfunction

	// Random relocation: mostly supported types with offsets near the immediate ranges,
	// some raw type numbers from the whole 8-bit space.
	function automatic reloc_t random_reloc();
		reloc_t r;
		logic [63:0] delta;
		if ($urandom_range(99) < 12)
			r.mode = 8'($urandom_range(255));
		else
			r.mode = known_mode(int'($urandom_range(12)));
		r.location = {$urandom, $urandom};
		if ($urandom_range(1)) begin
			r.addend = {$urandom, $urandom};
		end else begin
			r.addend = 64'($urandom_range(8191));
			r.addend = r.addend - 64'd4096;
		end
		if ($urandom_range(2) == 0) begin
			r.symbol_value = {$urandom, $urandom};
		end else begin
			// keep the PC-relative offset within a few megabytes, either sign
			delta = 64'($urandom_range(32'h7f_ffff));
			delta = delta - 64'h40_0000;
			r.symbol_value = r.location - r.addend + delta;
		end
		r.word_low = $urandom;
		r.word_high = $urandom;
		if ($urandom_range(1))
			r.pair_offset = $urandom;
		else
			r.pair_offset = 32'h7e0 + $urandom_range(63) - ($urandom_range(1) ? 32'h1000 : 32'h0);
		r.pair_found = ($urandom_range(9) != 0);
		return r;
	endfunction

	task automatic queue_reloc(input logic [7:0] m, input logic [63:0] loc,
			input logic [63:0] sym, input logic [63:0] add, input logic [31:0] w0,
			input logic [31:0] w1, input logic [31:0] pair, input logic found);
		reloc_t r;
		r.mode = m;
		r.location = loc;
		r.symbol_value = sym;
		r.addend = add;
		r.word_low = w0;
		r.word_high = w1;
		r.pair_offset = pair;
		r.pair_found = found;
		reloc_q.push_back(r);
	endtask

	task automatic queue_random(input int count);
		for (int i = 0; i < count; i++)
			reloc_q.push_back(random_reloc());
	endtask

	// Hold until every queued relocation has been offered and taken.
	task automatic wait_sent();
		while (reloc_q.size() != 0 || in_valid)
			@(negedge clk);
	endtask

	// Hold until, in addition, every owed result beat has come back.
	task automatic wait_drained();
		wait_sent();
		while (patched_words_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Driver: once the current beat is taken (or none is up), log what it owes and
	// offer the next entry unless this cycle is an idle one.
	always @(posedge clk) begin : drive_relocs
		logic offer;
		if (arst_n && (!in_valid || in_ready)) begin
			if (in_valid)
				patched_words_q.push_back(patch_words(cur_beat));
			offer = (reloc_q.size() != 0) && ($urandom_range(99) >= send_idle_pct);
			if (offer) begin
				cur_beat <= reloc_q.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: one long hold-off when armed, random back-pressure otherwise.
	always @(posedge clk) begin : accept_results
		if (hold_armed && !hold_done) begin
			out_ready <= 1'b0;
			hold_count <= hold_count + 1;
			if (hold_count == HOLD_CYCLES - 1)
				hold_done <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Monitor: compare each taken result beat against the oldest owed one.
	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (patched_words_q.size() == 0) begin
				$display("%0t: result beat with nothing owed, new_low %h status %0d",
					$time, new_low, status);
				mismatch_count++;
			end else begin
				want = patched_words_q.pop_front();
				check_field("new_low", want.new_low, new_low);
				check_field("new_high", want.new_high, new_high);
				check_field("write_high", 32'(want.write_high), 32'(write_high));
				check_field("half_only", 32'(want.half_only), 32'(half_only));
				check_field("status", 32'(want.status), 32'(status));
			end
		end
	end

	initial begin
		// Hold reset, then release it away from the sampling edge.
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed entries: field extremes, every type, rounding edges, wraps,
		// missing pairs and unknown types.
		queue_reloc(MODE_ABS64, 64'h0, '1, 64'd1, '1, '1, '0, 1'b0);
		queue_reloc(MODE_ABS64, '1, 64'h0123_4567_89ab_cdef, '1, '0, '0, '1, 1'b1);
		queue_reloc(MODE_HI20, BASE, BASE + 64'h7ff, 64'd0, '1, '0, '0, 1'b0);
		queue_reloc(MODE_HI20, BASE, BASE + 64'h800, 64'd0, '0, '1, '0, 1'b0);
		queue_reloc(MODE_HI20, BASE, BASE - 64'h800, 64'd0, 32'h0000_0597, '0, '0, 1'b0);
		queue_reloc(MODE_JAL, BASE, BASE + 64'h1f_fffe, 64'd0, 32'h0000_00ef, '0, '0, 1'b0);
		queue_reloc(MODE_JAL, BASE, BASE, -64'sd2, '1, '0, '0, 1'b0);
		queue_reloc(MODE_CALL, BASE, BASE + 64'h800, 64'd0, '1, '1, '0, 1'b0);
		queue_reloc(MODE_CALL_PLT, BASE, BASE - 64'h801, 64'd0, '0, '0, '0, 1'b0);
		queue_reloc(MODE_BRANCH, BASE, BASE + 64'h1ffe, 64'd0, '1, '0, '0, 1'b0);
		queue_reloc(MODE_BRANCH, BASE, BASE - 64'd2, 64'd0, '0, '1, '0, 1'b0);
		queue_reloc(MODE_RVC_JUMP, BASE, BASE + 64'hffe, 64'd0, '1, '0, '0, 1'b0);
		queue_reloc(MODE_RVC_JUMP, BASE, BASE - 64'd2, 64'd0, '0, '0, '0, 1'b0);
		queue_reloc(MODE_RVC_BRANCH, BASE, BASE + 64'h1fe, 64'd0, '1, '0, '0, 1'b0);
		queue_reloc(MODE_RVC_BRANCH, BASE, BASE - 64'd2, 64'd0, '0, '0, '0, 1'b0);
		queue_reloc(MODE_RELAX, BASE, '1, '1, '1, '1, '1, 1'b1);
		queue_reloc(MODE_ADD32, '0, 64'd1, 64'd0, '1, '0, '0, 1'b0);
		queue_reloc(MODE_SUB32, '0, 64'd1, 64'd0, '0, '0, '0, 1'b0);
		queue_reloc(MODE_LO12_I, BASE, '0, '0, '0, '0, 32'h7ff, 1'b1);
		queue_reloc(MODE_LO12_S, BASE, '0, '0, '1, '0, 32'h800, 1'b1);
		queue_reloc(MODE_LO12_I, BASE, '0, '0, '1, '1, 32'h123, 1'b0);
		queue_reloc(MODE_LO12_S, BASE, '0, '0, '0, '0, 32'h8000_0000, 1'b0);
		queue_reloc(8'd0, '1, '1, '1, '1, '1, '1, 1'b1);
		queue_reloc(8'd255, '0, '0, '0, '0, '0, '0, 1'b0);
		queue_reloc(8'd1, BASE, BASE, '0, 32'h1234_5678, 32'h9abc_def0, '0, 1'b1);

		// First idling mix: sender light, receiver heavy.
		queue_random(170);
		wait_sent();

		// Pause the sender until the block has handed back everything it owes.
		wait_drained();

		// Stall the receiver for a long stretch while the sender keeps offering beats,
		// so the pipeline fills and drops in_ready.
		send_idle_pct = 0;
		hold_armed = 1'b1;
		queue_random(40);
		while (!hold_done)
			@(negedge clk);
		wait_sent();

		// Swap the idling mix.
		send_idle_pct = 58;
		recv_idle_pct = 31;
		queue_random(170);
		wait_sent();

		// Full rate on both sides.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random(170);
		wait_drained();

		// Let any stray beat from the three-stage pipe show up before judging.
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog: the slowest legal run needs well under ten microseconds.
	initial begin
		#400us;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
